[hw/rtl/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants shared by the framebuffer present converter modules.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned FMT_W      = 3;
  localparam int unsigned WID_W      = 11;
  localparam int unsigned HGT_W      = 10;
  localparam int unsigned PITCH_W    = 13;
  localparam int unsigned X_W        = 10;
  localparam int unsigned Y_W        = 10;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned OFF_W      = 22;
  localparam int unsigned BYTES_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  // Shadow index y * width + x is at most 1023 * 2047 + 1023 < 2**21.
  localparam int unsigned IDX_W      = 21;

  typedef enum logic [FMT_W-1:0] {
    FMT_VGA16  = 3'd0,
    FMT_RGB565 = 3'd1,
    FMT_RGB332 = 3'd2,
    FMT_RGB888 = 3'd3,
    FMT_XRGB32 = 3'd4
  } fpc_fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_PITCH  = 2'd3
  } fpc_cfg_reg_e;

  // Register values after reset.
  localparam logic [FMT_W-1:0]   RST_FORMAT = FMT_XRGB32;
  localparam logic [WID_W-1:0]   RST_WIDTH  = 11'd640;
  localparam logic [HGT_W-1:0]   RST_HEIGHT = 10'd480;
  localparam logic [PITCH_W-1:0] RST_PITCH  = 13'd2560;

  // Color conversion constants.
  localparam logic [COLOR_W-1:0] MASK_565_R = 32'h0000_F800;
  localparam logic [COLOR_W-1:0] MASK_565_G = 32'h0000_07E0;
  localparam logic [COLOR_W-1:0] MASK_565_B = 32'h0000_001F;
  localparam logic [7:0]         MASK_332_RG = 8'hE0;
  localparam logic [7:0]         MASK_332_B  = 8'hC0;
  localparam logic [7:0]         VGA_LO      = 8'd85;
  localparam logic [7:0]         VGA_HI      = 8'd170;
  localparam logic [COLOR_W-1:0] SHADOW_INIT = 32'hFFFF_FFFF;

  // Surface configuration as seen by the datapath, with width and height
  // already clamped to the shadow dimensions.
  typedef struct packed {
    logic [FMT_W-1:0]   fmt;
    logic [WID_W-1:0]   width;
    logic [HGT_W-1:0]   height;
    logic [PITCH_W-1:0] pitch;
  } fpc_cfg_t;

endpackage

[hw/rtl/fpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fpc_cfg_regs
// Configuration register file with clamping of the surface dimensions.
// ----------------------------------------------------------------------------
module fpc_cfg_regs
  import fpc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 768
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output fpc_cfg_t              cfg_o
);

  logic [FMT_W-1:0]   fmt_q,    fmt_d;
  logic [WID_W-1:0]   width_q,  width_d;
  logic [HGT_W-1:0]   height_q, height_d;
  logic [PITCH_W-1:0] pitch_q,  pitch_d;

  always_comb begin
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    pitch_d  = pitch_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORMAT: fmt_d    = cfg_data_i[FMT_W-1:0];
        CFG_WIDTH:  width_d  = cfg_data_i[WID_W-1:0];
        CFG_HEIGHT: height_d = cfg_data_i[HGT_W-1:0];
        CFG_PITCH:  pitch_d  = cfg_data_i[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= RST_FORMAT;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      pitch_q  <= RST_PITCH;
    end else begin
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
      pitch_q  <= pitch_d;
    end
  end

  // A dimension beyond the shadow is taken as the shadow's own size, so the
  // clamped value always fits the register width when the clamp applies.
  always_comb begin
    cfg_o.fmt    = fmt_q;
    cfg_o.pitch  = pitch_q;
    cfg_o.width  = (32'(width_q) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : width_q;
    cfg_o.height = (32'(height_q) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : height_q;
  end

endmodule

[hw/rtl/fpc_shadow_mem.sv]
// ----------------------------------------------------------------------------
// fpc_shadow_mem
// Shadow color memory with a registered read port and a clearing sweep.
// ----------------------------------------------------------------------------
module fpc_shadow_mem
  import fpc_pkg::*;
#(
  parameter int unsigned DEPTH = 786432,
  parameter int unsigned AW    = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [COLOR_W-1:0] rd_data_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [COLOR_W-1:0] wr_data_i,
  output logic               clearing_o
);

  logic [COLOR_W-1:0] mem_q [DEPTH];
  logic [COLOR_W-1:0] rd_data_q;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic               clr_act_q,  clr_act_d;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [COLOR_W-1:0] wdata;

  // After reset every entry is swept to all ones, one entry a cycle.
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_act_d  = clr_act_q;
    if (clr_act_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_act_q  <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_act_q  <= clr_act_d;
    end
  end

  assign we    = clr_act_q | wr_en_i;
  assign waddr = clr_act_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_act_q ? SHADOW_INIT : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Read returns the old contents on a same-address write; the caller forwards.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_act_q;

endmodule

[hw/rtl/fpc_pixel_pack.sv]
// ----------------------------------------------------------------------------
// fpc_pixel_pack
// Converts a 32-bit xRGB color into the selected framebuffer pixel format.
// ----------------------------------------------------------------------------
module fpc_pixel_pack
  import fpc_pkg::*;
(
  input  logic [FMT_W-1:0]   fmt_i,
  input  logic [COLOR_W-1:0] color_i,
  output logic [COLOR_W-1:0] data_o,
  output logic [BYTES_W-1:0] bytes_o,
  output logic               fmt_ok_o
);

  logic [7:0]         red, green, blue;
  logic [3:0]         vga_idx;
  logic [COLOR_W-1:0] rgb565;
  logic [7:0]         rgb332;

  assign red   = color_i[23:16];
  assign green = color_i[15:8];
  assign blue  = color_i[7:0];

  always_comb begin
    vga_idx[2] = red > VGA_LO;
    vga_idx[1] = green > VGA_LO;
    vga_idx[0] = blue > VGA_LO;
    vga_idx[3] = (red > VGA_HI) || (green > VGA_HI) || (blue > VGA_HI);
  end

  assign rgb565 = ((color_i >> 8) & MASK_565_R) | ((color_i >> 5) & MASK_565_G)
                | ((color_i >> 3) & MASK_565_B);
  assign rgb332 = (red & MASK_332_RG) | ((green & MASK_332_RG) >> 3)
                | ((blue & MASK_332_B) >> 6);

  always_comb begin
    data_o   = '0;
    bytes_o  = '0;
    fmt_ok_o = 1'b1;
    case (fmt_i)
      FMT_VGA16: begin
        data_o  = {28'd0, vga_idx};
        bytes_o = 3'd1;
      end
      FMT_RGB565: begin
        data_o  = rgb565;
        bytes_o = 3'd2;
      end
      FMT_RGB332: begin
        data_o  = {24'd0, rgb332};
        bytes_o = 3'd1;
      end
      FMT_RGB888: begin
        data_o  = {8'd0, color_i[23:0]};
        bytes_o = 3'd3;
      end
      FMT_XRGB32: begin
        data_o  = color_i;
        bytes_o = 3'd4;
      end
      default: begin
        fmt_ok_o = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/framebuffer_present_converter_core.sv]
// ----------------------------------------------------------------------------
// framebuffer_present_converter_core
// Back-buffer pixel stream to framebuffer writes, with a shadow memory that
// suppresses writes of pixels whose color has not changed.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// pixel     in         start_i & !busy_o         pixel_x_i, pixel_y_i, color_in_i,
//                                                force_write_i
// result    out        done_o (one-cycle strobe) write_valid_o, out_x_o, out_y_o,
//                                                byte_offset_o, write_data_o,
//                                                write_bytes_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One pixel beat is accepted every cycle while busy_o is low. Each beat gives
// exactly one result beat, strobed by done_o after the compare stage and the
// result register. The rate is set by the shadow memory: one read port and
// one write port, with the read of a pixel overlapping the write of the one
// before it. After reset busy_o stays high while all MAX_WIDTH * MAX_HEIGHT
// shadow entries (786432 at the default sizes) are swept to all ones;
// configuration writes are still taken. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module framebuffer_present_converter_core
  import fpc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 768
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel beat
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [X_W-1:0]        pixel_x_i,
  input  logic [Y_W-1:0]        pixel_y_i,
  input  logic [COLOR_W-1:0]    color_in_i,
  input  logic                  force_write_i,
  // Result beat
  output logic                  done_o,
  output logic                  write_valid_o,
  output logic [X_W-1:0]        out_x_o,
  output logic [Y_W-1:0]        out_y_o,
  output logic [OFF_W-1:0]      byte_offset_o,
  output logic [COLOR_W-1:0]    write_data_o,
  output logic [BYTES_W-1:0]    write_bytes_o,
  // Configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  fpc_cfg_t cfg;
  logic     clearing;

  fpc_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // --------------------------------------------------------------------------
  // Accept stage: bounds check, shadow index and the row part of the offset.
  // The shadow read is issued at the accepting edge.
  // --------------------------------------------------------------------------
  logic                     s0_accept;
  logic                     s0_live;
  logic [IDX_W-1:0]         s0_row_base;
  logic [IDX_W-1:0]         s0_idx;
  logic [AW-1:0]            s0_addr;
  logic [Y_W+PITCH_W-1:0]   s0_ypitch;

  assign busy_o    = clearing;
  assign s0_accept = start_i & ~busy_o;

  // A zero width or height leaves no pixel inside; unknown formats never write.
  assign s0_live = ({1'b0, pixel_x_i} < cfg.width) && (pixel_y_i < cfg.height)
                && (cfg.fmt <= FMT_XRGB32);

  assign s0_row_base = pixel_y_i * cfg.width;
  assign s0_idx      = s0_row_base + IDX_W'(pixel_x_i);
  assign s0_addr     = AW'(s0_idx);
  assign s0_ypitch   = pixel_y_i * cfg.pitch;

  // --------------------------------------------------------------------------
  // Compare stage: shadow data arrives, the write decision is made and the
  // shadow entry is written back on the same edge.
  // --------------------------------------------------------------------------
  logic                     s1_valid_q;
  logic [X_W-1:0]           s1_x_q;
  logic [Y_W-1:0]           s1_y_q;
  logic [COLOR_W-1:0]       s1_color_q;
  logic                     s1_force_q;
  logic                     s1_live_q;
  logic [AW-1:0]            s1_addr_q;
  logic [OFF_W-1:0]         s1_ypitch_q;
  logic                     fwd_hit_q,  fwd_hit_d;
  logic [COLOR_W-1:0]       fwd_data_q;

  logic [COLOR_W-1:0]       rd_data;
  logic [COLOR_W-1:0]       s1_shadow;
  logic                     s1_vga;
  logic                     s1_shadow_we;
  logic                     s1_write;
  logic [COLOR_W-1:0]       s1_data;
  logic [BYTES_W-1:0]       s1_bytes;
  logic                     s1_fmt_ok;
  logic [X_W+BYTES_W-1:0]   s1_xbytes;
  logic [OFF_W-1:0]         s1_offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_accept) begin
      s1_x_q      <= pixel_x_i;
      s1_y_q      <= pixel_y_i;
      s1_color_q  <= color_in_i;
      s1_force_q  <= force_write_i;
      s1_live_q   <= s0_live;
      s1_addr_q   <= s0_addr;
      s1_ypitch_q <= s0_ypitch[OFF_W-1:0];
    end
    fwd_hit_q  <= fwd_hit_d;
    fwd_data_q <= s1_color_q;
  end

  fpc_shadow_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_shadow_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (s0_accept),
    .rd_addr_i  (s0_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (s1_shadow_we),
    .wr_addr_i  (s1_addr_q),
    .wr_data_i  (s1_color_q),
    .clearing_o (clearing)
  );

  fpc_pixel_pack u_pixel_pack (
    .fmt_i    (cfg.fmt),
    .color_i  (s1_color_q),
    .data_o   (s1_data),
    .bytes_o  (s1_bytes),
    .fmt_ok_o (s1_fmt_ok)
  );

  // The memory returns the old entry when the pixel just ahead writes the
  // same address on the reading edge, so that write is forwarded here.
  assign fwd_hit_d = s1_shadow_we && (s1_addr_q == s0_addr);
  assign s1_shadow = fwd_hit_q ? fwd_data_q : rd_data;

  assign s1_vga       = (cfg.fmt == FMT_VGA16);
  assign s1_shadow_we = s1_valid_q && s1_live_q && s1_fmt_ok && !s1_vga
                     && (s1_force_q || (s1_shadow != s1_color_q));
  assign s1_write     = s1_shadow_we || (s1_valid_q && s1_live_q && s1_vga);

  assign s1_xbytes = s1_x_q * s1_bytes;
  assign s1_offset = s1_vga ? '0 : (s1_ypitch_q + OFF_W'(s1_xbytes));

  // --------------------------------------------------------------------------
  // Result register: every field reads zero when no write is issued.
  // --------------------------------------------------------------------------
  logic                 done_q;
  logic                 wv_q;
  logic [X_W-1:0]       ox_q;
  logic [Y_W-1:0]       oy_q;
  logic [OFF_W-1:0]     off_q;
  logic [COLOR_W-1:0]   data_q;
  logic [BYTES_W-1:0]   bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      wv_q    <= s1_write;
      ox_q    <= s1_write ? s1_x_q : '0;
      oy_q    <= s1_write ? s1_y_q : '0;
      off_q   <= s1_write ? s1_offset : '0;
      data_q  <= s1_write ? s1_data : '0;
      bytes_q <= s1_write ? s1_bytes : '0;
    end
  end

  assign done_o        = done_q;
  assign write_valid_o = done_q & wv_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign byte_offset_o = off_q;
  assign write_data_o  = data_q;
  assign write_bytes_o = bytes_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_accept |-> ##2 done_o)
    else $error("accepted pixel produced no result beat");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s0_accept, 2))
    else $error("result beat without an accepted pixel");

  a_no_update_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_shadow_we)
    else $error("shadow update during the clearing sweep");

  a_vga_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_write && s1_vga) |=> (byte_offset_o == '0 && write_bytes_o == 3'd1))
    else $error("VGA write with nonzero offset or wrong byte count");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for framebuffer_present_converter_core. Pixel beats
// go in through the start/busy handshake. A predictor tracks the registers
// and the last color written for each pixel. It works out the framebuffer
// write that each beat should cause, or the all-zero result when the beat is
// skipped. Every done_o strobe is checked field by field against the oldest
// expected write.
// ----------------------------------------------------------------------------
module tb;
  import fpc_pkg::*;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 768;
  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned DRAIN_CYCLES  = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;
  // Reset sweep of the shadow plus all items, taken a few times over.
  localparam longint      LIMIT_CYCLES  = 2_500_000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 78;
  localparam int unsigned RECENT_DEPTH  = 12;

  // One framebuffer write as it appears on the result ports.
  typedef struct packed {
    logic               valid;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [OFF_W-1:0]   offset;
    logic [COLOR_W-1:0] data;
    logic [BYTES_W-1:0] nbytes;
  } fb_write_t;

  // A back-buffer pixel, kept so that it can be presented again.
  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [COLOR_W-1:0] color;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [X_W-1:0]        pixel_x_i = '0;
  logic [Y_W-1:0]        pixel_y_i = '0;
  logic [COLOR_W-1:0]    color_in_i = '0;
  logic                  force_write_i = 1'b0;
  logic                  done_o;
  logic                  write_valid_o;
  logic [X_W-1:0]        out_x_o;
  logic [Y_W-1:0]        out_y_o;
  logic [OFF_W-1:0]      byte_offset_o;
  logic [COLOR_W-1:0]    write_data_o;
  logic [BYTES_W-1:0]    write_bytes_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor state: a copy of the registers and of the shadow. Entries that
  // were never written read back as all ones, which is the shadow reset.
  logic [FMT_W-1:0]      fmt_q;
  logic [WID_W-1:0]      width_q;
  logic [HGT_W-1:0]      height_q;
  logic [PITCH_W-1:0]    pitch_q;
  logic [COLOR_W-1:0]    last_sent [int unsigned];

  fb_write_t             pending_writes [$];
  int unsigned           error_count = 0;
  bit                    steady_stream = 1'b0;

  framebuffer_present_converter_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .color_in_i    (color_in_i),
    .force_write_i (force_write_i),
    .done_o        (done_o),
    .write_valid_o (write_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .byte_offset_o (byte_offset_o),
    .write_data_o  (write_data_o),
    .write_bytes_o (write_bytes_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // 16-color index: each channel above the low threshold sets its own bit,
  // and any channel above the high threshold sets the intensity bit.
  function automatic logic [3:0] vga_index(logic [COLOR_W-1:0] c);
    logic [7:0] r, g, b;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    return {(r > VGA_HI) || (g > VGA_HI) || (b > VGA_HI), r > VGA_LO, g > VGA_LO, b > VGA_LO};
  endfunction

  // Works out the write for one pixel beat and updates the shadow copy.
  // A skipped beat leaves every field of the result at zero.
  function automatic fb_write_t convert_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                              logic [COLOR_W-1:0] c, logic f);
    fb_write_t   w;
    int unsigned wid, hgt, idx, bpp;
    logic [31:0] off;
    logic [COLOR_W-1:0] data, shadow;
    w = '0;
    // Oversized surfaces saturate at the shadow dimensions.
    wid = (width_q > MAX_W) ? MAX_W : width_q;
    hgt = (height_q > MAX_H) ? MAX_H : height_q;
    if (x >= wid || y >= hgt || fmt_q > FMT_XRGB32) begin
      return w;
    end
    w.valid = 1'b1;
    w.x     = x;
    w.y     = y;
    // The planar mode always writes and neither reads nor updates the shadow.
    if (fmt_q == FMT_VGA16) begin
      w.data   = {28'b0, vga_index(c)};
      w.nbytes = 3'd1;
      return w;
    end
    idx    = y * wid + x;
    shadow = last_sent.exists(idx) ? last_sent[idx] : SHADOW_INIT;
    if (!f && shadow == c) begin
      return '0;
    end
    case (fmt_q)
      FMT_RGB565: begin
        bpp  = 2;
        data = {16'b0, c[23:19], c[15:10], c[7:3]};
      end
      FMT_RGB332: begin
        bpp  = 1;
        data = {24'b0, c[23:21], c[15:13], c[7:6]};
      end
      FMT_RGB888: begin
        bpp  = 3;
        data = {8'b0, c[23:0]};
      end
      default: begin
        bpp  = 4;
        data = c;
      end
    endcase
    last_sent[idx] = c;
    // The framebuffer offset wraps at its port width.
    off      = y * pitch_q + x * bpp;
    w.offset = off[OFF_W-1:0];
    w.data   = data;
    w.nbytes = bpp[BYTES_W-1:0];
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------

  task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Register writes are only issued while no beat is in flight, so the
  // predictor can take the new value at once.
  task automatic write_reg(fpc_cfg_reg_e reg_idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= reg_idx;
    cfg_data_i <= value;
    case (reg_idx)
      CFG_FORMAT: fmt_q    = value[FMT_W-1:0];
      CFG_WIDTH:  width_q  = value[WID_W-1:0];
      CFG_HEIGHT: height_q = value[HGT_W-1:0];
      CFG_PITCH:  pitch_q  = value[PITCH_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Presents one pixel beat and holds it until busy_o lets it in. start_i
  // stays high afterwards, so back-to-back calls stream one beat per cycle
  // while busy_o is low; now and then the sender drops start_i between beats.
  task automatic send_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                            logic [COLOR_W-1:0] c, logic f);
    @(negedge clk_i);
    start_i       <= 1'b1;
    pixel_x_i     <= x;
    pixel_y_i     <= y;
    color_in_i    <= c;
    force_write_i <= f;
    do @(posedge clk_i); while (busy_o);
    pending_writes.push_back(convert_pixel(x, y, c, f));
    if (!steady_stream && $urandom_range(99) < 4) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
  endtask

  // Stops the sender and waits until every expected write has come back,
  // then waits out a settling time to catch a stray strobe.
  task automatic settle_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_writes.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_writes.size() != 0) begin
      report_error("missing results", pending_writes.size(), 0);
      pending_writes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result checker. Results cannot be stalled, so every done_o strobe must
  // match the oldest expected write.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    fb_write_t want;
    if (rst_ni && done_o) begin
      if (pending_writes.size() == 0) begin
        report_error("unexpected result", {out_y_o, out_x_o}, 0);
      end else begin
        want = pending_writes.pop_front();
        if (write_valid_o !== want.valid)  report_error("write_valid", write_valid_o, want.valid);
        if (out_x_o !== want.x)            report_error("out_x", out_x_o, want.x);
        if (out_y_o !== want.y)            report_error("out_y", out_y_o, want.y);
        if (byte_offset_o !== want.offset) report_error("byte_offset", byte_offset_o, want.offset);
        if (write_data_o !== want.data)    report_error("write_data", write_data_o, want.data);
        if (write_bytes_o !== want.nbytes) report_error("write_bytes", write_bytes_o, want.nbytes);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: 32-bit format on a 640 x 480 surface. An all-ones pixel
  // matches the cleared shadow and is skipped unless forced; a repeated
  // pixel is skipped; pixels just past the surface edges are dropped.
  task automatic test_reset_state();
    logic [COLOR_W-1:0] c;
    c = $urandom();
    send_pixel(10'd0, 10'd0, 32'hFFFF_FFFF, 1'b0);
    send_pixel(10'd0, 10'd0, 32'hFFFF_FFFF, 1'b1);
    send_pixel(10'd639, 10'd479, c, 1'b0);
    send_pixel(10'd639, 10'd479, c, 1'b0);
    send_pixel(10'd639, 10'd479, c, 1'b1);
    send_pixel(10'd640, 10'd0, c, 1'b0);
    send_pixel(10'd0, 10'd480, c, 1'b0);
    settle_results();
  endtask

  // Largest surface and pitch, so the far corner wraps the byte offset, in
  // every linear format and in two of the three unused format codes.
  task automatic test_format_extremes();
    logic [FMT_W-1:0] fmt_list [6];
    fmt_list = '{FMT_RGB565, FMT_RGB332, FMT_RGB888, FMT_XRGB32, 3'd5, 3'd7};
    write_reg(CFG_WIDTH, CFG_DATA_W'(MAX_W));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(MAX_H));
    write_reg(CFG_PITCH, 13'h1FFF);
    foreach (fmt_list[i]) begin
      write_reg(CFG_FORMAT, CFG_DATA_W'(fmt_list[i]));
      send_pixel(10'd1023, 10'd767, $urandom(), 1'b0);
      settle_results();
    end
  endtask

  // Planar mode: channels exactly on and just past both thresholds. Force
  // makes no difference here, and the shadow is left alone.
  task automatic test_vga_thresholds();
    write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_VGA16));
    write_reg(CFG_WIDTH, 13'd640);
    write_reg(CFG_HEIGHT, 13'd480);
    send_pixel(10'd0, 10'd0, 32'h0055_5555, 1'b0);
    send_pixel(10'd1, 10'd0, 32'hFF56_5656, 1'b0);
    send_pixel(10'd639, 10'd479, 32'h00AA_AAAA, 1'b1);
    send_pixel(10'd2, 10'd3, 32'h00AB_0000, 1'b0);
    send_pixel(10'd2, 10'd3, 32'h0000_00AB, 1'b0);
    send_pixel(10'd640, 10'd0, 32'h00FF_FFFF, 1'b0);
    settle_results();
  endtask

  // Surface sizes past the shadow saturate, zero sizes hold no pixel, and
  // the smallest surface holds only its origin.
  task automatic test_surface_limits();
    write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_RGB888));
    write_reg(CFG_WIDTH, 13'h7FF);
    write_reg(CFG_HEIGHT, 13'h3FF);
    write_reg(CFG_PITCH, 13'd0);
    send_pixel(10'd1023, 10'd767, $urandom(), 1'b1);
    send_pixel(10'd5, 10'd768, $urandom(), 1'b1);
    settle_results();
    write_reg(CFG_WIDTH, 13'd0);
    send_pixel(10'd0, 10'd0, $urandom(), 1'b1);
    settle_results();
    write_reg(CFG_WIDTH, 13'd1);
    write_reg(CFG_HEIGHT, 13'd0);
    send_pixel(10'd0, 10'd0, $urandom(), 1'b1);
    settle_results();
    write_reg(CFG_HEIGHT, 13'd1);
    write_reg(CFG_PITCH, 13'd1);
    send_pixel(10'd0, 10'd0, $urandom(), 1'b0);
    send_pixel(10'd1, 10'd0, $urandom(), 1'b0);
    send_pixel(10'd0, 10'd1, $urandom(), 1'b0);
    settle_results();
  endtask

  // Random frames. Each phase picks a setting and then presents pixels
  // mostly inside a small surface, drawn from a small palette and often
  // presented again, so the shadow both hits and misses. Some beats are
  // noise over the full field ranges. One phase uses an oversized surface,
  // and one streams without gaps.
  task automatic test_random_frames();
    pixel_t             recent [$];
    pixel_t             px;
    logic [COLOR_W-1:0] palette [4];
    int unsigned        roll, span_x, span_y;
    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(CFG_FORMAT, CFG_DATA_W'((phase < 5) ? phase : $urandom_range(0, 7)));
      if (phase == 6) begin
        write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(MAX_W, 2047)));
        write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(MAX_H, 1023)));
      end else begin
        write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(1, 16)));
        write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
      end
      write_reg(CFG_PITCH, CFG_DATA_W'($urandom_range(0, 8191)));
      // One past the clamped edge is allowed so the edges get exercised; x stops at 1023.
      span_x = (width_q > 1023) ? 1023 : width_q;
      span_y = (height_q > MAX_H) ? MAX_H : height_q;
      steady_stream = (phase == 3);
      recent.delete();
      foreach (palette[i]) palette[i] = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 15) begin
          px.x     = X_W'($urandom());
          px.y     = Y_W'($urandom());
          px.color = $urandom();
        end else if (roll < 55 && recent.size() != 0) begin
          px = recent[$urandom_range(0, recent.size() - 1)];
          if ($urandom_range(3) == 0) px.color = palette[$urandom_range(0, 3)];
        end else begin
          px.x     = X_W'($urandom_range(0, span_x));
          px.y     = Y_W'($urandom_range(0, span_y));
          px.color = palette[$urandom_range(0, 3)];
        end
        send_pixel(px.x, px.y, px.color, $urandom_range(7) == 0);
        recent.push_back(px);
        if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
      end
      // The sender holds off until every write of this phase is back.
      settle_results();
    end
    steady_stream = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    fmt_q    = RST_FORMAT;
    width_q  = RST_WIDTH;
    height_q = RST_HEIGHT;
    pitch_q  = RST_PITCH;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The first beat waits out the shadow sweep behind busy_o.
    test_reset_state();
    test_format_extremes();
    test_vga_thresholds();
    test_surface_limits();
    test_random_frames();
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog for a handshake that never completes.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb: FAIL");
    $finish;
  end

endmodule
